@@ rtl/core/lsht_pkg.sv @@
// Shared types and constants for the line segment hit test unit.
// Used by the channel interfaces, the configuration block, the top level and the checker.
`default_nettype none

package lsht_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_IDX_BITS   = 3;
    localparam int BYTE_BITS      = 8;
    localparam int REGION_BITS    = 2;
    localparam int TOL_BITS       = 9;
    localparam int TOL_SQ_BITS    = 17;

    // fixed band tolerance of four plus one for the strict compare
    localparam logic [BYTE_BITS-1:0] BAND_BASE  = 8'd5;
    localparam logic [BYTE_BITS-1:0] STROKE_RST = 8'd1;
    localparam logic [BYTE_BITS-1:0] CORNER_RST = 8'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_X   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_Y   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STROKE  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER  = 3'd5;

    typedef enum logic [REGION_BITS-1:0] {
        REGION_START,
        REGION_END,
        REGION_BAND,
        REGION_OUT
    } t_region;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_DIFF,
        SQ_SQUARE,
        SQ_SUM,
        SQ_ROOT_K,
        SQ_PREP,
        SQ_MUL_P,
        SQ_ROOT_P,
        SQ_MUL_C,
        SQ_ROOT_C
    } t_seq_state;

    typedef struct packed {
        logic busy;
        logic zero_len;
    } t_cfg_status;

endpackage

`default_nettype wire

@@ rtl/core/lsht_ifs.sv @@
// Valid/ready channel interfaces: probe words in, region words out, register writes.
// Depends on lsht_pkg.
`default_nettype none

interface lsht_probe_if #(
    parameter int COORD_BITS = lsht_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] probe_x;
    logic signed [COORD_BITS-1:0] probe_y;

    modport source (output valid, output probe_x, output probe_y, input ready);
    modport sink   (input valid, input probe_x, input probe_y, output ready);
endinterface

interface lsht_region_if ();
    import lsht_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [REGION_BITS-1:0] region;

    modport source (output valid, output region, input ready);
    modport sink   (input valid, input region, output ready);
endinterface

interface lsht_cfg_if #(
    parameter int COORD_BITS = lsht_pkg::COORD_BITS_DEF
) ();
    import lsht_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [COORD_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lsht_cfg.sv @@
// Register file and threshold sequencer for the hit test unit.
// Holds the segment registers and derives the band limits with a shared root and product unit.
`default_nettype none

module lsht_cfg #(
    parameter int COORD_BITS = lsht_pkg::COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_wr_en,
    input  logic [lsht_pkg::CFG_IDX_BITS-1:0]      i_wr_index,
    input  logic [COORD_BITS-1:0]                  i_wr_data,
    output logic signed [COORD_BITS-1:0]           o_start_x,
    output logic signed [COORD_BITS-1:0]           o_start_y,
    output logic signed [COORD_BITS-1:0]           o_end_x,
    output logic signed [COORD_BITS-1:0]           o_end_y,
    output logic [lsht_pkg::BYTE_BITS-1:0]         o_corner,
    output logic signed [COORD_BITS:0]             o_dx,
    output logic signed [COORD_BITS:0]             o_dy,
    output logic [2*COORD_BITS+1:0]                o_lim_neg,
    output logic [2*COORD_BITS+1:0]                o_lim_pos,
    output logic [2*COORD_BITS+1:0]                o_lim_cross,
    output lsht_pkg::t_cfg_status                  o_status
);
    import lsht_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int DW = 2 * N + 2;
    localparam int KW = 2 * N + 1;
    localparam int QW = N + 1;
    localparam int BW = 2 * QW;
    localparam int RW = 4 * N + 4;
    localparam logic [RW-1:0] RT_BIT0 = {2'b01, {(RW - 2){1'b0}}};

    t_seq_state r_state, n_state;

    logic signed [N-1:0]    r_sx, r_sy, r_ex, r_ey;
    logic [BYTE_BITS-1:0]   r_stroke, r_corner;
    logic                   r_zero;
    logic signed [N:0]      r_dx, r_dy;
    logic [2*N-1:0]         r_dx2, r_dy2;
    logic [KW-1:0]          r_k;
    logic [QW-1:0]          r_q;
    logic [TOL_SQ_BITS-1:0] r_tsq;
    logic [RW-1:0]          r_rt_n, r_rt_res, r_rt_bit;
    logic [RW-1:0]          r_mu_acc, r_mu_a;
    logic [BW-1:0]          r_mu_b;
    logic [DW-1:0]          r_lim_neg, r_lim_pos, r_lim_cross;

    logic                   wr_geo;
    logic signed [2*N+1:0]  dx_sq, dy_sq;
    logic [KW-1:0]          k_sum;
    logic [QW-1:0]          q_inc;
    logic [BW-1:0]          q1_sq;
    logic [TOL_BITS-1:0]    tol;
    logic [2*TOL_BITS-1:0]  tol_full;
    logic [RW-1:0]          rt_try, rt_n_nx, rt_res_nx, rt_lim_full;
    logic                   rt_ge, rt_last, mu_done;

    assign wr_geo = i_wr_en && (i_wr_index <= REG_STROKE);

    assign dx_sq    = (2 * N + 2)'(r_dx) * (2 * N + 2)'(r_dx);
    assign dy_sq    = (2 * N + 2)'(r_dy) * (2 * N + 2)'(r_dy);
    assign k_sum    = KW'(r_dx2) + KW'(r_dy2);
    assign q_inc    = r_q + QW'(1);
    assign q1_sq    = BW'(q_inc) * BW'(q_inc);
    assign tol      = TOL_BITS'(r_stroke) + TOL_BITS'(BAND_BASE);
    assign tol_full = (2 * TOL_BITS)'(tol) * (2 * TOL_BITS)'(tol);

    assign rt_try      = r_rt_res + r_rt_bit;
    assign rt_ge       = r_rt_n >= rt_try;
    assign rt_n_nx     = rt_ge ? r_rt_n - rt_try : r_rt_n;
    assign rt_res_nx   = rt_ge ? (r_rt_res >> 1) + r_rt_bit : r_rt_res >> 1;
    assign rt_last     = r_rt_bit[0];
    // largest t with t*t below the operand
    assign rt_lim_full = (rt_n_nx == '0) ? rt_res_nx - RW'(1) : rt_res_nx;
    assign mu_done     = (r_mu_b == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SQ_IDLE:   ;
            SQ_DIFF:   n_state = SQ_SQUARE;
            SQ_SQUARE: n_state = SQ_SUM;
            SQ_SUM:    n_state = SQ_ROOT_K;
            SQ_ROOT_K: if (rt_last) n_state = SQ_PREP;
            SQ_PREP:   n_state = SQ_MUL_P;
            SQ_MUL_P:  if (mu_done) n_state = SQ_ROOT_P;
            SQ_ROOT_P: if (rt_last) n_state = SQ_MUL_C;
            SQ_MUL_C:  if (mu_done) n_state = SQ_ROOT_C;
            SQ_ROOT_C: if (rt_last) n_state = SQ_IDLE;
            default:   n_state = SQ_IDLE;
        endcase
        if (wr_geo) n_state = SQ_DIFF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SQ_IDLE;
            r_sx     <= '0;
            r_sy     <= '0;
            r_ex     <= '0;
            r_ey     <= '0;
            r_stroke <= STROKE_RST;
            r_corner <= CORNER_RST;
            r_zero   <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == SQ_SUM) r_zero <= (k_sum == '0);
            if (i_wr_en) begin
                unique case (i_wr_index)
                    REG_START_X: r_sx     <= i_wr_data;
                    REG_START_Y: r_sy     <= i_wr_data;
                    REG_END_X:   r_ex     <= i_wr_data;
                    REG_END_Y:   r_ey     <= i_wr_data;
                    REG_STROKE:  r_stroke <= i_wr_data[BYTE_BITS-1:0];
                    REG_CORNER:  r_corner <= i_wr_data[BYTE_BITS-1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            SQ_IDLE: ;
            SQ_DIFF: begin
                r_dx <= (N + 1)'(r_sx) - (N + 1)'(r_ex);
                r_dy <= (N + 1)'(r_sy) - (N + 1)'(r_ey);
            end
            SQ_SQUARE: begin
                r_dx2 <= dx_sq[2*N-1:0];
                r_dy2 <= dy_sq[2*N-1:0];
            end
            SQ_SUM: begin
                r_k      <= k_sum;
                r_rt_n   <= RW'(k_sum);
                r_rt_res <= '0;
                r_rt_bit <= RT_BIT0;
            end
            SQ_ROOT_K: begin
                r_rt_n   <= rt_n_nx;
                r_rt_res <= rt_res_nx;
                r_rt_bit <= r_rt_bit >> 2;
                if (rt_last) begin
                    r_q       <= rt_res_nx[QW-1:0];
                    r_lim_neg <= rt_lim_full[DW-1:0];
                end
            end
            SQ_PREP: begin
                r_mu_acc <= '0;
                r_mu_a   <= RW'(r_k);
                r_mu_b   <= q1_sq;
                r_tsq    <= tol_full[TOL_SQ_BITS-1:0];
            end
            SQ_MUL_P, SQ_MUL_C: begin
                if (mu_done) begin
                    r_rt_n   <= r_mu_acc;
                    r_rt_res <= '0;
                    r_rt_bit <= RT_BIT0;
                end else begin
                    if (r_mu_b[0]) r_mu_acc <= r_mu_acc + r_mu_a;
                    r_mu_a <= r_mu_a << 1;
                    r_mu_b <= r_mu_b >> 1;
                end
            end
            SQ_ROOT_P: begin
                r_rt_n   <= rt_n_nx;
                r_rt_res <= rt_res_nx;
                r_rt_bit <= r_rt_bit >> 2;
                if (rt_last) begin
                    r_lim_pos <= rt_lim_full[DW-1:0];
                    r_mu_acc  <= '0;
                    r_mu_a    <= RW'(r_k);
                    r_mu_b    <= BW'(r_tsq);
                end
            end
            SQ_ROOT_C: begin
                r_rt_n   <= rt_n_nx;
                r_rt_res <= rt_res_nx;
                r_rt_bit <= r_rt_bit >> 2;
                if (rt_last) r_lim_cross <= rt_lim_full[DW-1:0];
            end
            default: ;
        endcase
    end

    assign o_start_x         = r_sx;
    assign o_start_y         = r_sy;
    assign o_end_x           = r_ex;
    assign o_end_y           = r_ey;
    assign o_corner          = r_corner;
    assign o_dx              = r_dx;
    assign o_dy              = r_dy;
    assign o_lim_neg         = r_lim_neg;
    assign o_lim_pos         = r_lim_pos;
    assign o_lim_cross       = r_lim_cross;
    assign o_status.busy     = (r_state != SQ_IDLE);
    assign o_status.zero_len = r_zero;

endmodule

`default_nettype wire

@@ rtl/core/line_segment_hit_test_unit.sv @@
// Top level of the line segment hit test unit: five-stage probe pipeline.
// Depends on lsht_pkg, lsht_ifs and lsht_cfg.
//
// Each probe word is classified against the configured segment as start box, end box,
// segment band or outside. The pipeline takes one probe per cycle while probe ready is high,
// which receiver back-pressure or a limit recompute can hold low, and shows its region from
// the last of its input, difference, product, sum and compare registers; bubbles let it keep
// taking probes while a result waits. The band limits are exact integer thresholds derived
// from the segment registers by a bit-serial square root and shift-add product unit: after
// a write to a coordinate or stroke register, probe ready stays low until the limits are
// recomputed. Register writes are taken in every cycle; the corner register applies at once.
`default_nettype none

module line_segment_hit_test_unit #(
    parameter int COORD_BITS = lsht_pkg::COORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lsht_cfg_if.sink      i_cfg,
    lsht_probe_if.sink    i_probe,
    lsht_region_if.source o_region
);
    import lsht_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int DW = 2 * N + 2;

    logic signed [N-1:0]  sx, sy, ex, ey;
    logic [BYTE_BITS-1:0] corner;
    logic signed [N:0]    dx, dy;
    logic [DW-1:0]        lim_neg, lim_pos, lim_cross;
    t_cfg_status          status;

    lsht_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (i_cfg.valid),
        .i_wr_index  (i_cfg.index),
        .i_wr_data   (i_cfg.data),
        .o_start_x   (sx),
        .o_start_y   (sy),
        .o_end_x     (ex),
        .o_end_y     (ey),
        .o_corner    (corner),
        .o_dx        (dx),
        .o_dy        (dy),
        .o_lim_neg   (lim_neg),
        .o_lim_pos   (lim_pos),
        .o_lim_cross (lim_cross),
        .o_status    (status)
    );

    assign i_cfg.ready = 1'b1;

    function automatic logic in_box(input logic signed [N:0] dd_x,
                                    input logic signed [N:0] dd_y,
                                    input logic [BYTE_BITS-1:0] half);
        logic [N:0] m_x;
        logic [N:0] m_y;
        m_x = dd_x[N] ? -dd_x : dd_x;
        m_y = dd_y[N] ? -dd_y : dd_y;
        return (m_x <= (N + 1)'(half)) && (m_y <= (N + 1)'(half));
    endfunction

    logic                r_a_v, r_b_v, r_c_v, r_d_v, r_o_v;
    logic                ld_a, ld_b, ld_c, ld_d, ld_o;
    logic signed [N-1:0] r_a_px, r_a_py;
    logic signed [N:0]   r_b_vx, r_b_vy;
    logic                r_b_hs, r_b_he, r_c_hs, r_c_he, r_d_hs, r_d_he;
    logic signed [DW-1:0] r_c_xx, r_c_yy, r_c_xy, r_c_yx;
    logic signed [DW-1:0] r_d_dot, r_d_cross;
    t_region             r_o_region, n_region;

    logic signed [N:0]   vx, vy, ds_x, ds_y, de_x, de_y;
    logic                dot_neg, dot_ok, band;
    logic [DW-1:0]       dot_mag, cross_mag;

    assign ld_o = !r_o_v || o_region.ready;
    assign ld_d = !r_d_v || ld_o;
    assign ld_c = !r_c_v || ld_d;
    assign ld_b = !r_b_v || ld_c;
    assign ld_a = !r_a_v || ld_b;

    assign i_probe.ready = ld_a && !status.busy;

    assign vx   = (N + 1)'(r_a_px) - (N + 1)'(ex);
    assign vy   = (N + 1)'(r_a_py) - (N + 1)'(ey);
    assign ds_x = (N + 1)'(r_a_px) - (N + 1)'(sx);
    assign ds_y = (N + 1)'(r_a_py) - (N + 1)'(sy);
    assign de_x = vx;
    assign de_y = vy;

    assign dot_neg   = r_d_dot[DW-1];
    assign dot_mag   = dot_neg ? -r_d_dot : r_d_dot;
    assign cross_mag = r_d_cross[DW-1] ? -r_d_cross : r_d_cross;
    assign dot_ok    = (r_d_dot == '0) ||
                       (dot_neg ? (dot_mag <= lim_neg) : (dot_mag <= lim_pos));
    assign band      = !status.zero_len && dot_ok && (cross_mag <= lim_cross);

    always_comb begin
        if (r_d_hs) begin
            n_region = REGION_START;
        end else if (r_d_he) begin
            n_region = REGION_END;
        end else if (band) begin
            n_region = REGION_BAND;
        end else begin
            n_region = REGION_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (ld_a) r_a_v <= i_probe.valid && i_probe.ready;
            if (ld_b) r_b_v <= r_a_v;
            if (ld_c) r_c_v <= r_b_v;
            if (ld_d) r_d_v <= r_c_v;
            if (ld_o) r_o_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_a) begin
            r_a_px <= i_probe.probe_x;
            r_a_py <= i_probe.probe_y;
        end
        if (ld_b) begin
            r_b_vx <= vx;
            r_b_vy <= vy;
            r_b_hs <= in_box(ds_x, ds_y, corner);
            r_b_he <= in_box(de_x, de_y, corner);
        end
        if (ld_c) begin
            r_c_xx <= DW'(dx) * DW'(r_b_vx);
            r_c_yy <= DW'(dy) * DW'(r_b_vy);
            r_c_xy <= DW'(dx) * DW'(r_b_vy);
            r_c_yx <= DW'(dy) * DW'(r_b_vx);
            r_c_hs <= r_b_hs;
            r_c_he <= r_b_he;
        end
        if (ld_d) begin
            r_d_dot   <= r_c_xx + r_c_yy;
            r_d_cross <= r_c_xy - r_c_yx;
            r_d_hs    <= r_c_hs;
            r_d_he    <= r_c_he;
        end
        if (ld_o) r_o_region <= n_region;
    end

    assign o_region.valid  = r_o_v;
    assign o_region.region = r_o_region;

endmodule

`default_nettype wire

@@ rtl/core/lsht_checker.sv @@
// Port-level checks for line_segment_hit_test_unit and the bind that attaches them.
// Depends on lsht_pkg and the top level's channel interfaces.
`default_nettype none

module lsht_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_valid,
    input logic                                i_cfg_ready,
    input logic [lsht_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input logic                                i_probe_ready,
    input logic                                i_region_valid,
    input logic                                i_region_ready,
    input logic [lsht_pkg::REGION_BITS-1:0]    i_region
);
    import lsht_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_region_valid && !i_region_ready |=> i_region_valid)
        else $error("region word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_region_valid && !i_region_ready |=> $stable(i_region))
        else $error("region word changed while stalled");

    a_recompute_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_ready && (i_cfg_index <= REG_STROKE) |=> !i_probe_ready)
        else $error("probe taken while limits are recomputed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_region_valid)
        else $error("region word shown right after reset");

endmodule

bind line_segment_hit_test_unit lsht_checker u_lsht_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_valid    (i_cfg.valid),
    .i_cfg_ready    (i_cfg.ready),
    .i_cfg_index    (i_cfg.index),
    .i_probe_ready  (i_probe.ready),
    .i_region_valid (o_region.valid),
    .i_region_ready (o_region.ready),
    .i_region       (o_region.region)
);

`default_nettype wire

@@ tb/line_segment_hit_test_unit_tb.sv @@
// Self-checking testbench for line_segment_hit_test_unit: probe words are classified
// by an in-bench integer predictor and compared with each region word, under stalls.
// Depends on lsht_pkg, lsht_ifs and the unit's top level.
`timescale 1ns / 100ps

module line_segment_hit_test_unit_tb;
    import lsht_pkg::*;

    localparam int COORD_W      = COORD_BITS_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int COORD_MIN    = -(1 << (COORD_W - 1));
    localparam int COORD_MAX    = (1 << (COORD_W - 1)) - 1;

    localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;

    lsht_cfg_if   #(.COORD_BITS(COORD_W)) cfg_bus ();
    lsht_probe_if #(.COORD_BITS(COORD_W)) probe_bus ();
    lsht_region_if                        region_bus ();

    line_segment_hit_test_unit #(.COORD_BITS(COORD_W)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_probe  (probe_bus),
        .o_region (region_bus)
    );

    logic signed [COORD_W-1:0] seg_sx, seg_sy, seg_ex, seg_ey;
    logic [BYTE_BITS-1:0]      stroke_w, corner_c;

    t_region expected_regions[$];
    int      error_count    = 0;
    int      probes_sent    = 0;
    int      results_seen   = 0;
    int      settings_used  = 0;
    int      src_idle_pct   = 0;
    int      sink_stall_pct = 0;
    logic    hold_active    = 1'b0;
    event    start_hold;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned mag_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bit_w;
        root  = 0;
        bit_w = 64'h4000_0000_0000_0000;
        while (bit_w > n) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (n >= root + bit_w) begin
                n    = n - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    function automatic t_region classify_probe(input logic signed [COORD_W-1:0] px_in,
                                               input logic signed [COORD_W-1:0] py_in);
        longint px, py, sx, sy, ex, ey, dx, dy, vx, vy, dot, crs;
        longint unsigned c, k, q;
        logic [127:0] dot_sq, cross_sq, k_w, q1_sq, tol_sq;
        px = px_in;
        py = py_in;
        sx = seg_sx;
        sy = seg_sy;
        ex = seg_ex;
        ey = seg_ey;
        c  = corner_c;
        if (mag_of(px - sx) <= c && mag_of(py - sy) <= c) return REGION_START;
        if (mag_of(px - ex) <= c && mag_of(py - ey) <= c) return REGION_END;
        dx = sx - ex;
        dy = sy - ey;
        vx = px - ex;
        vy = py - ey;
        k  = dx * dx + dy * dy;
        if (k == 0) return (px == sx && py == sy) ? REGION_BAND : REGION_OUT;
        q        = floor_sqrt(k);
        dot      = dx * vx + dy * vy;
        crs      = dx * vy - dy * vx;
        k_w      = k;
        dot_sq   = mag_of(dot);
        dot_sq   = dot_sq * dot_sq;
        cross_sq = mag_of(crs);
        cross_sq = cross_sq * cross_sq;
        q1_sq    = q + 1;
        q1_sq    = q1_sq * q1_sq;
        tol_sq   = 5 + stroke_w;
        tol_sq   = tol_sq * tol_sq;
        if (dot < 0 && !(dot_sq < k_w)) return REGION_OUT;
        if (dot > 0 && !(dot_sq < q1_sq * k_w)) return REGION_OUT;
        return (cross_sq < tol_sq * k_w) ? REGION_BAND : REGION_OUT;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < COORD_MIN) return COORD_MIN;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        region_bus.ready <= !hold_active && ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        forever begin
            @(start_hold);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_region want;
        if (i_rst_n) begin
            if (probe_bus.valid && probe_bus.ready)
                expected_regions.push_back(classify_probe(probe_bus.probe_x, probe_bus.probe_y));
            if (region_bus.valid && region_bus.ready) begin
                results_seen++;
                if (expected_regions.size() == 0) begin
                    report_mismatch($sformatf("region word %0d with nothing expected",
                                              region_bus.region));
                end else begin
                    want = expected_regions.pop_front();
                    if (region_bus.region !== want)
                        report_mismatch($sformatf("region got %0d, want %0d (%s)",
                                                  region_bus.region, want, want.name()));
                end
            end
        end
    end

    task automatic send_probe(input int px, input int py);
        if ($urandom_range(99) < src_idle_pct) begin
            probe_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        probe_bus.valid   <= 1'b1;
        probe_bus.probe_x <= COORD_W'(px);
        probe_bus.probe_y <= COORD_W'(py);
        do @(posedge i_clk); while (!probe_bus.ready);
        probes_sent++;
    endtask

    task automatic probe_idle();
        probe_bus.valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        do @(posedge i_clk); while (expected_regions.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [COORD_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            REG_START_X: seg_sx   = val;
            REG_START_Y: seg_sy   = val;
            REG_END_X:   seg_ex   = val;
            REG_END_Y:   seg_ey   = val;
            REG_STROKE:  stroke_w = val[BYTE_BITS-1:0];
            REG_CORNER:  corner_c = val[BYTE_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // drop probes, drain, then load a whole segment setting
    task automatic set_segment(input int sx, input int sy, input int ex, input int ey,
                               input logic [COORD_W-1:0] stroke_word,
                               input logic [COORD_W-1:0] corner_word);
        probe_idle();
        wait_for_results();
        write_reg(REG_START_X, COORD_W'(sx));
        write_reg(REG_START_Y, COORD_W'(sy));
        write_reg(REG_END_X, COORD_W'(ex));
        write_reg(REG_END_Y, COORD_W'(ey));
        write_reg(REG_STROKE, stroke_word);
        write_reg(REG_CORNER, corner_word);
        settings_used++;
    endtask

    task automatic randomize_segment();
        int sx, sy, ex, ey, stroke, corner;
        sx = rand_coord();
        sy = rand_coord();
        case ($urandom_range(9))
            0: begin
                ex = sx;
                ey = sy;
            end
            1, 2, 3, 4: begin
                ex = clamp_coord(sx + int'($urandom_range(400)) - 200);
                ey = clamp_coord(sy + int'($urandom_range(400)) - 200);
            end
            5: begin
                ex = rand_coord();
                ey = sy;
            end
            6: begin
                ex = sx;
                ey = rand_coord();
            end
            default: begin
                ex = rand_coord();
                ey = rand_coord();
            end
        endcase
        stroke = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(12);
        corner = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(8);
        set_segment(sx, sy, ex, ey, {8'($urandom), 8'(stroke)}, {8'($urandom), 8'(corner)});
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? IDX_SPARE_HI : IDX_SPARE_LO, COORD_W'($urandom));
    endtask

    // mostly near the band and the grab boxes, the rest anywhere
    task automatic send_random_probe();
        int dx, dy, t, spread, pick, px, py;
        dx   = seg_sx - seg_ex;
        dy   = seg_sy - seg_ey;
        pick = $urandom_range(99);
        if (pick < 45) begin
            t      = int'($urandom_range(1100)) - 50;
            spread = stroke_w + 8;
            px = seg_ex + dx * t / 1000 + int'($urandom_range(2 * spread)) - spread;
            py = seg_ey + dy * t / 1000 + int'($urandom_range(2 * spread)) - spread;
        end else if (pick < 70) begin
            spread = corner_c + 2;
            if ($urandom_range(1)) begin
                px = seg_sx;
                py = seg_sy;
            end else begin
                px = seg_ex;
                py = seg_ey;
            end
            px = px + int'($urandom_range(2 * spread)) - spread;
            py = py + int'($urandom_range(2 * spread)) - spread;
        end else begin
            px = rand_coord();
            py = rand_coord();
        end
        send_probe(clamp_coord(px), clamp_coord(py));
    endtask

    task automatic test_reset_defaults();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_probe(0, 0);
        send_probe(3, -3);
        send_probe(4, 0);
        send_probe(0, -4);
    endtask

    task automatic test_band_limits();
        set_segment(-100, 0, 100, 0, 16'd1, 16'd3);
        send_probe(-100, 0);
        send_probe(100, 3);
        send_probe(103, -3);
        send_probe(104, 0);
        send_probe(0, 5);
        send_probe(0, 6);
        send_probe(0, -5);
        send_probe(100, 5);
        send_probe(101, 5);
        send_probe(-100, 5);
        send_probe(-101, 5);
    endtask

    task automatic test_extremes();
        set_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 16'hA5FF, 16'h5A00);
        send_probe(COORD_MIN, COORD_MIN);
        send_probe(COORD_MAX, COORD_MAX);
        send_probe(COORD_MAX, COORD_MIN);
        send_probe(0, 0);
        send_probe(COORD_MIN, COORD_MAX);
        set_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 16'hFF00, 16'h00FF);
        write_reg(IDX_SPARE_LO, 16'hFFFF);
        write_reg(IDX_SPARE_HI, 16'h1234);
        send_probe(COORD_MIN + 255, COORD_MIN + 255);
        send_probe(COORD_MAX - 256, COORD_MAX);
        send_probe(0, 1);
    endtask

    task automatic test_random_traffic(input int n_items, input int n_settings,
                                       input int src_pct, input int sink_pct);
        int per_setting;
        per_setting = n_items / n_settings;
        for (int s = 0; s < n_settings; s++) begin
            randomize_segment();
            src_idle_pct   = src_pct;
            sink_stall_pct = sink_pct;
            for (int n = 0; n < per_setting; n++) send_random_probe();
            src_idle_pct   = 0;
            sink_stall_pct = 0;
        end
    endtask

    task automatic test_backpressure();
        randomize_segment();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        -> start_hold;
        for (int n = 0; n < 40; n++) send_random_probe();
        // pause until every result is back, then resume under stalls
        probe_idle();
        wait_for_results();
        sink_stall_pct = 58;
        for (int n = 0; n < 30; n++) send_random_probe();
        sink_stall_pct = 0;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = REG_START_X;
        cfg_bus.data      = '0;
        probe_bus.valid   = 1'b0;
        probe_bus.probe_x = '0;
        probe_bus.probe_y = '0;
        region_bus.ready  = 1'b0;
        seg_sx            = '0;
        seg_sy            = '0;
        seg_ex            = '0;
        seg_ey            = '0;
        stroke_w          = STROKE_RST;
        corner_c          = CORNER_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_band_limits();
        test_extremes();
        test_random_traffic(440, 8, 0, 0);
        test_random_traffic(440, 8, 58, 0);
        test_random_traffic(440, 8, 0, 58);
        test_random_traffic(440, 8, 25, 25);
        test_backpressure();

        probe_idle();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_regions.size() != 0)
            report_mismatch($sformatf("%0d region words never arrived",
                                      expected_regions.size()));

        $display("Checked %0d region words from %0d probe words over %0d segment settings,",
                 results_seen, probes_sent, settings_used);
        $display("with sender gaps, receiver stalls and a long receiver hold-off.");
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(3_000_000);
        $display("Timeout with %0d region words outstanding", expected_regions.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
